### design/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // Field and register widths
    localparam int RAW_W      = 12;
    localparam int HUM_W      = 12;
    localparam int TIN_W      = 11;
    localparam int AMB_W      = 8;
    localparam int LIM_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Raw range and search
    localparam int RAW_MAX      = 4095;
    localparam int RAW_HALF     = RAW_MAX / 2;
    localparam int RAW_QUARTER  = RAW_MAX / 4;
    localparam int SEARCH_STEPS = 20;
    localparam int STEP_W       = (SEARCH_STEPS > 1) ? $clog2(SEARCH_STEPS) : 1;

    // Reference temperatures and ceiling, Celsius
    localparam int REF_C0   = 200;
    localparam int REF_C1   = 260;
    localparam int REF_C2   = 330;
    localparam int REF_C3   = 400;
    localparam int TEMP_TOP = 999;

    // Interpolation unit widths
    localparam int LIN_IN_W = 14;
    localparam int DIFF_W   = LIN_IN_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int MAG_W    = 24;
    localparam int DEN_W    = DIFF_W;
    localparam int LIN_W    = 28;
    localparam int CNT_W    = $clog2(MAG_W);

    typedef enum logic [1:0] {
        KIND_FWD  = 2'd0,
        KIND_INV  = 2'd1,
        KIND_LP   = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CP0     = 3'd0,
        CFG_CP1     = 3'd1,
        CFG_CP2     = 3'd2,
        CFG_CP3     = 3'd3,
        CFG_CAL_AMB = 3'd4,
        CFG_USE_C   = 3'd5,
        CFG_LIM_MIN = 3'd6,
        CFG_LIM_MAX = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_FWD_START,
        ST_FWD_WAIT,
        ST_FWD_CLAMP,
        ST_FWD_FAHR,
        ST_SEARCH,
        ST_CONV,
        ST_TCLAMP,
        ST_GUESS_START,
        ST_GUESS_WAIT,
        ST_GUESS_ADJ,
        ST_LP_CELS,
        ST_LP_CHECK,
        ST_LP_START,
        ST_LP_WAIT,
        ST_DONE
    } st_t;

    typedef enum logic [1:0] {
        LIN_IDLE,
        LIN_MUL,
        LIN_DIV,
        LIN_FIN
    } lin_st_t;

    // F = (9*C + 162) / 5, truncated toward zero; /5 by reciprocal
    function automatic logic signed [HUM_W-1:0] to_fahr(input logic signed [HUM_W-1:0] c);
        logic signed [15:0] n;
        logic [14:0]        m;
        logic [30:0]        p;
        logic [HUM_W-1:0]   q;
        n = $signed({{(16-HUM_W){c[HUM_W-1]}}, c}) * 16'sd9 + 16'sd162;
        m = n[15] ? 15'(-n) : n[14:0];
        p = 31'(m) * 31'd52429;
        q = p[18+HUM_W-1:18];
        return n[15] ? $signed(-q) : $signed(q);
    endfunction

    // C = ((F-32)*5 + 4) / 9 above 32 F, else 0; /9 by reciprocal
    function automatic logic [TIN_W-1:0] to_cels(input logic [TIN_W-1:0] f);
        logic [13:0] n;
        logic [29:0] p;
        n = '0;
        p = '0;
        if (f > TIN_W'(32))
        begin
            n = 14'(f - TIN_W'(32)) * 14'd5 + 14'd4;
            p = 30'(n) * 30'd58255;
        end
        return p[19+TIN_W-1:19];
    endfunction

endpackage

`default_nettype wire

### design/tcc_lin.sv
`timescale 1ns / 1ps
`default_nettype none

// Truncating interpolation (x-a)*(dd-c)/(b-a)+c; bit-serial restoring divide
module tcc_lin (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tcc_pkg::LIN_IN_W-1:0]  x,
    input  logic signed [tcc_pkg::LIN_IN_W-1:0]  a,
    input  logic signed [tcc_pkg::LIN_IN_W-1:0]  b,
    input  logic signed [tcc_pkg::LIN_IN_W-1:0]  c,
    input  logic signed [tcc_pkg::LIN_IN_W-1:0]  dd,
    output logic                                 done,
    output logic signed [tcc_pkg::LIN_W-1:0]     q
);

    tcc_pkg::lin_st_t state_reg, state_next;

    logic signed [tcc_pkg::DIFF_W-1:0]   xa_reg, dc_reg, ba_reg;
    logic signed [tcc_pkg::LIN_IN_W-1:0] c_reg;
    logic [tcc_pkg::MAG_W-1:0]           num_reg;
    logic [tcc_pkg::DEN_W-1:0]           den_reg, rem_reg;
    logic                                neg_reg;
    logic [tcc_pkg::CNT_W-1:0]           cnt_reg;
    logic                                done_reg;
    logic signed [tcc_pkg::LIN_W-1:0]    q_reg;

    logic signed [tcc_pkg::PROD_W-1:0]   prod;
    logic [tcc_pkg::PROD_W-1:0]          prod_mag;
    logic [tcc_pkg::DEN_W:0]             shifted;
    logic                                fits;
    logic signed [tcc_pkg::LIN_W-1:0]    q_signed, c_ext;

    assign prod     = xa_reg * dc_reg;
    assign prod_mag = prod[tcc_pkg::PROD_W-1] ? tcc_pkg::PROD_W'(-prod)
                                              : tcc_pkg::PROD_W'(prod);
    assign shifted  = {rem_reg, num_reg[tcc_pkg::MAG_W-1]};
    assign fits     = shifted >= {1'b0, den_reg};
    assign c_ext    = $signed({{(tcc_pkg::LIN_W-tcc_pkg::LIN_IN_W){c_reg[tcc_pkg::LIN_IN_W-1]}},
                               c_reg});
    assign q_signed = neg_reg ? -$signed({{(tcc_pkg::LIN_W-tcc_pkg::MAG_W){1'b0}}, num_reg})
                              :  $signed({{(tcc_pkg::LIN_W-tcc_pkg::MAG_W){1'b0}}, num_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcc_pkg::LIN_IDLE: if (start) state_next = tcc_pkg::LIN_MUL;
            tcc_pkg::LIN_MUL:  state_next = (ba_reg == '0) ? tcc_pkg::LIN_IDLE
                                                           : tcc_pkg::LIN_DIV;
            tcc_pkg::LIN_DIV:  if (cnt_reg == tcc_pkg::CNT_W'(tcc_pkg::MAG_W - 1))
                                   state_next = tcc_pkg::LIN_FIN;
            tcc_pkg::LIN_FIN:  state_next = tcc_pkg::LIN_IDLE;
            default:           state_next = tcc_pkg::LIN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcc_pkg::LIN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == tcc_pkg::LIN_MUL) && (ba_reg == '0))
                      || (state_reg == tcc_pkg::LIN_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tcc_pkg::LIN_IDLE:
            begin
                if (start)
                begin
                    xa_reg <= $signed({x[tcc_pkg::LIN_IN_W-1], x}) - $signed({a[tcc_pkg::LIN_IN_W-1], a});
                    dc_reg <= $signed({dd[tcc_pkg::LIN_IN_W-1], dd}) - $signed({c[tcc_pkg::LIN_IN_W-1], c});
                    ba_reg <= $signed({b[tcc_pkg::LIN_IN_W-1], b}) - $signed({a[tcc_pkg::LIN_IN_W-1], a});
                    c_reg  <= c;
                end
            end
            tcc_pkg::LIN_MUL:
            begin
                // equal ends give the lower output end
                if (ba_reg == '0)
                    q_reg <= c_ext;
                num_reg <= prod_mag[tcc_pkg::MAG_W-1:0];
                neg_reg <= prod[tcc_pkg::PROD_W-1] ^ ba_reg[tcc_pkg::DIFF_W-1];
                den_reg <= ba_reg[tcc_pkg::DIFF_W-1] ? tcc_pkg::DEN_W'(-ba_reg)
                                                     : tcc_pkg::DEN_W'(ba_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            tcc_pkg::LIN_DIV:
            begin
                rem_reg <= fits ? tcc_pkg::DEN_W'(shifted - {1'b0, den_reg})
                                : shifted[tcc_pkg::DEN_W-1:0];
                num_reg <= {num_reg[tcc_pkg::MAG_W-2:0], fits};
                cnt_reg <= cnt_reg + tcc_pkg::CNT_W'(1);
            end
            tcc_pkg::LIN_FIN:
            begin
                q_reg <= q_signed + c_ext;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

### design/thermocouple_calibration_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Input transfer to out_valid: raw to human runs one forward evaluation; human to raw runs setup,
// a guess, then up to 20 forward evaluations, each paced by the 24-step serial divide; low power
// runs one interpolation at or below 200 C, else the human-to-raw search. Throughput: one item at
// a time; the next transfer is taken once the result sits in the output register. Reset: asynchronous,
// active low; configuration returns to its reset values, sequencer and output valid clear.
module thermocouple_calibration_converter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [tcc_pkg::RAW_W-1:0]         raw_temp,
    input  logic [tcc_pkg::TIN_W-1:0]         human_temp,
    input  logic signed [tcc_pkg::AMB_W-1:0]  ambient_temp,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcc_pkg::RAW_W-1:0]         value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LW = tcc_pkg::LIN_IN_W;
    localparam int HW = tcc_pkg::HUM_W;

    // Configuration registers
    logic [tcc_pkg::RAW_W-1:0]        cp0_reg, cp1_reg, cp2_reg, cp3_reg;
    logic signed [tcc_pkg::AMB_W-1:0] cal_amb_reg;
    logic                             use_c_reg;
    logic [tcc_pkg::LIM_W-1:0]        lim_min_reg, lim_max_reg;

    // Sequencer and working registers
    tcc_pkg::st_t                     state_reg, state_next;
    tcc_pkg::kind_t                   kind_reg;
    logic [tcc_pkg::TIN_W-1:0]        t_in_reg, tc_reg;
    logic signed [tcc_pkg::AMB_W-1:0] amb_reg;
    logic signed [tcc_pkg::AMB_W:0]   d_reg;
    logic [tcc_pkg::RAW_W-1:0]        r_reg, left_reg, right_reg, res_reg;
    logic [tcc_pkg::STEP_W-1:0]       step_reg;
    logic [1:0]                       conv_reg;
    logic signed [HW-1:0]             t200_reg, t400_reg, tmin_reg, tmax_reg, t_reg;
    logic [9:0]                       hc_reg;
    logic [HW-1:0]                    h_reg;
    logic                             out_valid_reg;
    logic [tcc_pkg::RAW_W-1:0]        value_reg;

    // Interpolation unit
    logic                             lin_start, lin_done;
    logic signed [LW-1:0]             lin_x, lin_a, lin_b, lin_c, lin_dd;
    logic signed [tcc_pkg::LIN_W-1:0] lin_q;

    // Datapath helpers
    logic signed [LW-1:0]             d_ext, amb_ext, ref0, ref1, ref2, ref3;
    logic signed [LW-1:0]             cp0_s, cp1_s, cp2_s, cp3_s;
    logic signed [tcc_pkg::LIN_W-1:0] amb_wide, h_clamp;
    logic [tcc_pkg::RAW_W-1:0]        lin_sat, guess_adj;
    logic signed [HW-1:0]             conv_x, conv_y, t_cand, fahr_h;
    logic                             search_eq, search_lt, search_last;
    logic [tcc_pkg::RAW_W:0]          mid_sum;
    logic [tcc_pkg::RAW_W-1:0]        mid, r_new;
    logic                             in_xfer, out_load;

    assign in_stall  = (state_reg != tcc_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == tcc_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp0_reg     <= 12'd680;
            cp1_reg     <= 12'd964;
            cp2_reg     <= 12'd1290;
            cp3_reg     <= 12'd1600;
            cal_amb_reg <= 8'sd25;
            use_c_reg   <= 1'b1;
            lim_min_reg <= 10'd180;
            lim_max_reg <= 10'd450;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tcc_pkg::cfg_idx_t'(cfg_index))
                tcc_pkg::CFG_CP0:     cp0_reg     <= cfg_data;
                tcc_pkg::CFG_CP1:     cp1_reg     <= cfg_data;
                tcc_pkg::CFG_CP2:     cp2_reg     <= cfg_data;
                tcc_pkg::CFG_CP3:     cp3_reg     <= cfg_data;
                tcc_pkg::CFG_CAL_AMB: cal_amb_reg <= $signed(cfg_data[tcc_pkg::AMB_W-1:0]);
                tcc_pkg::CFG_USE_C:   use_c_reg   <= cfg_data[0];
                tcc_pkg::CFG_LIM_MIN: lim_min_reg <= cfg_data[tcc_pkg::LIM_W-1:0];
                tcc_pkg::CFG_LIM_MAX: lim_max_reg <= cfg_data[tcc_pkg::LIM_W-1:0];
                default:              use_c_reg   <= use_c_reg;
            endcase
        end
    end

    // Ambient-shifted references and widened operands
    assign d_ext   = $signed({{(LW-tcc_pkg::AMB_W-1){d_reg[tcc_pkg::AMB_W]}}, d_reg});
    assign amb_ext = $signed({{(LW-tcc_pkg::AMB_W){amb_reg[tcc_pkg::AMB_W-1]}}, amb_reg});
    assign ref0    = LW'(tcc_pkg::REF_C0) + d_ext;
    assign ref1    = LW'(tcc_pkg::REF_C1) + d_ext;
    assign ref2    = LW'(tcc_pkg::REF_C2) + d_ext;
    assign ref3    = LW'(tcc_pkg::REF_C3) + d_ext;
    assign cp0_s   = $signed({{(LW-tcc_pkg::RAW_W){1'b0}}, cp0_reg});
    assign cp1_s   = $signed({{(LW-tcc_pkg::RAW_W){1'b0}}, cp1_reg});
    assign cp2_s   = $signed({{(LW-tcc_pkg::RAW_W){1'b0}}, cp2_reg});
    assign cp3_s   = $signed({{(LW-tcc_pkg::RAW_W){1'b0}}, cp3_reg});

    // Interpolation operands: segment pick for the forward map, or the guess
    // line, or the low-power line
    always_comb
    begin
        lin_start = (state_reg == tcc_pkg::ST_FWD_START)
                 || (state_reg == tcc_pkg::ST_GUESS_START)
                 || (state_reg == tcc_pkg::ST_LP_START);
        lin_x  = $signed({{(LW-tcc_pkg::RAW_W){1'b0}}, r_reg});
        lin_a  = '0;
        lin_b  = cp0_s;
        lin_c  = amb_ext;
        lin_dd = ref0;
        priority if (state_reg == tcc_pkg::ST_GUESS_START)
        begin
            lin_x  = $signed({{(LW-HW){t_reg[HW-1]}}, t_reg});
            lin_a  = $signed({{(LW-HW){t200_reg[HW-1]}}, t200_reg});
            lin_b  = $signed({{(LW-HW){t400_reg[HW-1]}}, t400_reg});
            lin_c  = cp0_s;
            lin_dd = cp3_s;
        end
        else if (state_reg == tcc_pkg::ST_LP_START)
        begin
            lin_x  = $signed({{(LW-tcc_pkg::TIN_W){1'b0}}, tc_reg});
            lin_a  = amb_ext;
            lin_b  = ref0;
            lin_c  = '0;
            lin_dd = cp0_s;
        end
        else if (r_reg < cp0_reg)
        begin
            // below the first point: 0..point 0 onto ambient..reference 0
            lin_a = '0;
        end
        else if (r_reg <= cp3_reg)
        begin
            // first segment whose upper point exceeds the reading, else the last segment
            priority if (r_reg < cp1_reg)
            begin
                lin_a = cp0_s; lin_b = cp1_s; lin_c = ref0; lin_dd = ref1;
            end
            else if (r_reg < cp2_reg)
            begin
                lin_a = cp1_s; lin_b = cp2_s; lin_c = ref1; lin_dd = ref2;
            end
            else
            begin
                lin_a = cp2_s; lin_b = cp3_s; lin_c = ref2; lin_dd = ref3;
            end
        end
        else
        begin
            // beyond the last point: extend the line through points 1 and 3
            lin_a = cp1_s; lin_b = cp3_s; lin_c = ref1; lin_dd = ref3;
        end
    end

    tcc_lin u_lin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lin_start),
        .x     (lin_x),
        .a     (lin_a),
        .b     (lin_b),
        .c     (lin_c),
        .dd    (lin_dd),
        .done  (lin_done),
        .q     (lin_q)
    );

    // Clamp the forward result to ambient..999, then to no less than zero
    assign amb_wide = $signed({{(tcc_pkg::LIN_W-tcc_pkg::AMB_W){amb_reg[tcc_pkg::AMB_W-1]}},
                               amb_reg});
    always_comb
    begin
        h_clamp = (lin_q < amb_wide) ? amb_wide : lin_q;
        if (h_clamp > tcc_pkg::LIN_W'(tcc_pkg::TEMP_TOP))
            h_clamp = tcc_pkg::LIN_W'(tcc_pkg::TEMP_TOP);
        if (h_clamp < 0)
            h_clamp = '0;
    end

    // Saturate an interpolated raw value to the raw range
    always_comb
    begin
        priority if (lin_q < 0)
            lin_sat = '0;
        else if (lin_q > tcc_pkg::LIN_W'(tcc_pkg::RAW_MAX))
            lin_sat = tcc_pkg::RAW_W'(tcc_pkg::RAW_MAX);
        else
            lin_sat = lin_q[tcc_pkg::RAW_W-1:0];
    end

    // Shift the first guess a quarter range: down if above half range, else up
    assign guess_adj = (lin_sat > tcc_pkg::RAW_W'(tcc_pkg::RAW_HALF))
                     ? lin_sat - tcc_pkg::RAW_W'(tcc_pkg::RAW_QUARTER)
                     : lin_sat + tcc_pkg::RAW_W'(tcc_pkg::RAW_QUARTER);

    // Limits and reference ends in human units, one conversion a cycle
    always_comb
    begin
        unique case (conv_reg)
            2'd0:    conv_x = HW'(tcc_pkg::REF_C0) + HW'(d_ext);
            2'd1:    conv_x = HW'(tcc_pkg::REF_C3) + HW'(d_ext);
            2'd2:    conv_x = $signed({{(HW-tcc_pkg::LIM_W){1'b0}}, lim_min_reg});
            default: conv_x = $signed({{(HW-tcc_pkg::LIM_W){1'b0}}, lim_max_reg});
        endcase
        conv_y = use_c_reg ? conv_x : tcc_pkg::to_fahr(conv_x);
    end

    // Target clamp: lower limit first, upper limit otherwise
    always_comb
    begin
        t_cand = $signed({{(HW-tcc_pkg::TIN_W){1'b0}}, t_in_reg});
        priority if (t_cand < tmin_reg)
            t_cand = tmin_reg;
        else if (t_cand > tmax_reg)
            t_cand = tmax_reg;
    end

    assign fahr_h = tcc_pkg::to_fahr($signed({{(HW-10){1'b0}}, hc_reg}));

    // Bisection step
    assign search_eq   = $signed({1'b0, h_reg}) == $signed({t_reg[HW-1], t_reg});
    assign search_lt   = $signed({1'b0, h_reg}) <  $signed({t_reg[HW-1], t_reg});
    assign search_last = (step_reg == tcc_pkg::STEP_W'(tcc_pkg::SEARCH_STEPS - 1));
    assign mid_sum     = search_lt ? {1'b0, r_reg} + {1'b0, right_reg}
                                   : {1'b0, left_reg} + {1'b0, r_reg};
    assign mid         = mid_sum[tcc_pkg::RAW_W:1];
    always_comb
    begin
        r_new = mid;
        if (mid == r_reg)
        begin
            // no progress: nudge one step, held inside the raw range
            if (search_lt)
                r_new = (r_reg == tcc_pkg::RAW_W'(tcc_pkg::RAW_MAX)) ? r_reg
                                                                    : r_reg + 1'b1;
            else
                r_new = (r_reg == '0) ? r_reg : r_reg - 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcc_pkg::ST_IDLE:        if (in_xfer) state_next = tcc_pkg::ST_PREP;
            tcc_pkg::ST_PREP:
            begin
                unique case (kind_reg)
                    tcc_pkg::KIND_FWD: state_next = tcc_pkg::ST_FWD_START;
                    tcc_pkg::KIND_INV: state_next = tcc_pkg::ST_CONV;
                    tcc_pkg::KIND_LP:  state_next = tcc_pkg::ST_LP_CELS;
                    default:           state_next = tcc_pkg::ST_DONE;
                endcase
            end
            tcc_pkg::ST_FWD_START:   state_next = tcc_pkg::ST_FWD_WAIT;
            tcc_pkg::ST_FWD_WAIT:    if (lin_done) state_next = tcc_pkg::ST_FWD_CLAMP;
            tcc_pkg::ST_FWD_CLAMP:   state_next = tcc_pkg::ST_FWD_FAHR;
            tcc_pkg::ST_FWD_FAHR:    state_next = (kind_reg == tcc_pkg::KIND_FWD)
                                                ? tcc_pkg::ST_DONE : tcc_pkg::ST_SEARCH;
            tcc_pkg::ST_SEARCH:      state_next = (search_eq || search_last)
                                                ? tcc_pkg::ST_DONE : tcc_pkg::ST_FWD_START;
            tcc_pkg::ST_CONV:        if (conv_reg == 2'd3) state_next = tcc_pkg::ST_TCLAMP;
            tcc_pkg::ST_TCLAMP:      state_next = tcc_pkg::ST_GUESS_START;
            tcc_pkg::ST_GUESS_START: state_next = tcc_pkg::ST_GUESS_WAIT;
            tcc_pkg::ST_GUESS_WAIT:  if (lin_done) state_next = tcc_pkg::ST_GUESS_ADJ;
            tcc_pkg::ST_GUESS_ADJ:   state_next = tcc_pkg::ST_FWD_START;
            tcc_pkg::ST_LP_CELS:     state_next = tcc_pkg::ST_LP_CHECK;
            tcc_pkg::ST_LP_CHECK:    state_next = (tc_reg > tcc_pkg::TIN_W'(tcc_pkg::REF_C0))
                                                ? tcc_pkg::ST_CONV : tcc_pkg::ST_LP_START;
            tcc_pkg::ST_LP_START:    state_next = tcc_pkg::ST_LP_WAIT;
            tcc_pkg::ST_LP_WAIT:     if (lin_done) state_next = tcc_pkg::ST_DONE;
            tcc_pkg::ST_DONE:        if (out_load) state_next = tcc_pkg::ST_IDLE;
            default:                 state_next = tcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tcc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tcc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_reg <= tcc_pkg::kind_t'(kind);
                    t_in_reg <= human_temp;
                    amb_reg  <= ambient_temp;
                    r_reg    <= raw_temp;
                end
            end
            tcc_pkg::ST_PREP:
            begin
                d_reg    <= $signed({amb_reg[tcc_pkg::AMB_W-1], amb_reg})
                          - $signed({cal_amb_reg[tcc_pkg::AMB_W-1], cal_amb_reg});
                conv_reg <= 2'd0;
                res_reg  <= '0;
            end
            tcc_pkg::ST_FWD_CLAMP: hc_reg <= h_clamp[9:0];
            tcc_pkg::ST_FWD_FAHR:
            begin
                h_reg <= use_c_reg ? {{(HW-10){1'b0}}, hc_reg} : fahr_h;
                if (kind_reg == tcc_pkg::KIND_FWD)
                    res_reg <= use_c_reg ? {{(HW-10){1'b0}}, hc_reg} : fahr_h;
            end
            tcc_pkg::ST_SEARCH:
            begin
                if (search_eq)
                    res_reg <= r_reg;
                else
                begin
                    if (search_lt)
                        left_reg  <= r_reg;
                    else
                        right_reg <= r_reg;
                    r_reg    <= r_new;
                    res_reg  <= r_new;
                    step_reg <= step_reg + tcc_pkg::STEP_W'(1);
                end
            end
            tcc_pkg::ST_CONV:
            begin
                unique case (conv_reg)
                    2'd0:    t200_reg <= conv_y;
                    2'd1:    t400_reg <= conv_y;
                    2'd2:    tmin_reg <= conv_y;
                    default: tmax_reg <= conv_y;
                endcase
                conv_reg <= conv_reg + 2'd1;
            end
            tcc_pkg::ST_TCLAMP: t_reg <= t_cand;
            tcc_pkg::ST_GUESS_ADJ:
            begin
                r_reg     <= guess_adj;
                left_reg  <= '0;
                right_reg <= tcc_pkg::RAW_W'(tcc_pkg::RAW_MAX);
                step_reg  <= '0;
            end
            tcc_pkg::ST_LP_CELS:
                tc_reg <= use_c_reg ? t_in_reg : tcc_pkg::to_cels(t_in_reg);
            tcc_pkg::ST_LP_WAIT:
                if (lin_done) res_reg <= lin_sat;
            default:
                conv_reg <= conv_reg;
        endcase
    end

    // Output register: hold the result until the far side takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            value_reg <= res_reg;
    end

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == tcc_pkg::ST_PREP))
        else $error("accepted item did not start the sequencer");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        lin_done |-> (state_reg == tcc_pkg::ST_FWD_WAIT)
                  || (state_reg == tcc_pkg::ST_GUESS_WAIT)
                  || (state_reg == tcc_pkg::ST_LP_WAIT))
        else $error("interpolation finished outside a wait state");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcc_pkg::ST_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not moved to the output register");

endmodule

`default_nettype wire
